### design/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared types and constants of the 3x3 matrix inverse block: request and
// response structs, internal widths and the cofactor product tables.
// ----------------------------------------------------------------------------
package mi3_pkg;

   // element word and element count
   localparam int WORD_BITS = 32;
   localparam int NUM_ELEM  = 9;

   // internal widths: products, cofactors, determinant, cofactor magnitude
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int COF_BITS  = 2 * WORD_BITS + 1;
   localparam int DET_BITS  = 3 * WORD_BITS + 3;
   localparam int MAG_BITS  = 2 * WORD_BITS;

   typedef logic signed [WORD_BITS-1:0] mi3_word_type;
   typedef logic [COF_BITS-1:0]         mi3_cof_type;
   typedef logic [MAG_BITS-1:0]         mi3_mag_type;
   typedef logic [DET_BITS-1:0]         mi3_dmag_type;

   typedef struct packed {
      mi3_word_type m_r0c0;
      mi3_word_type m_r0c1;
      mi3_word_type m_r0c2;
      mi3_word_type m_r1c0;
      mi3_word_type m_r1c1;
      mi3_word_type m_r1c2;
      mi3_word_type m_r2c0;
      mi3_word_type m_r2c1;
      mi3_word_type m_r2c2;
   } mi3_req_type;

   typedef struct packed {
      mi3_word_type inv_r0c0;
      mi3_word_type inv_r0c1;
      mi3_word_type inv_r0c2;
      mi3_word_type inv_r1c0;
      mi3_word_type inv_r1c1;
      mi3_word_type inv_r1c2;
      mi3_word_type inv_r2c0;
      mi3_word_type inv_r2c1;
      mi3_word_type inv_r2c2;
      mi3_word_type det_value;
      logic         is_singular;
      logic         saturated_flag;
   } mi3_rsp_type;

   // per-request information that rides beside the divider lanes
   typedef struct packed {
      logic                singular;
      logic                det_sat;
      logic [NUM_ELEM-1:0] neg;
      mi3_word_type        det_word;
   } mi3_side_type;

   // cofactor i = m[PROD_A[2i]]*m[PROD_B[2i]] - m[PROD_A[2i+1]]*m[PROD_B[2i+1]]
   localparam int PROD_A [2*NUM_ELEM] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
   localparam int PROD_B [2*NUM_ELEM] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

endpackage

### design/mi3_cofactor.sv
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: eighteen 32x32 products, then the nine adjugate cofactors.
// Row 0 of the matrix travels along for the determinant expansion.
// ----------------------------------------------------------------------------
module mi3_cofactor (
   input  logic                                          clock,
   input  logic                                          adv,
   input  mi3_pkg::mi3_req_type                          req,
   output mi3_pkg::mi3_cof_type [mi3_pkg::NUM_ELEM-1:0]  cof,
   output mi3_pkg::mi3_word_type [2:0]                   row0
);
   import mi3_pkg::*;

   mi3_word_type                   m [NUM_ELEM];
   logic signed [PROD_BITS-1:0]    prod_ff [2*NUM_ELEM];
   mi3_word_type [2:0]             row0_s1_ff;
   mi3_word_type [2:0]             row0_ff;
   mi3_cof_type [NUM_ELEM-1:0]     cof_ff;

   // unpack the request
   assign m[0] = req.m_r0c0;
   assign m[1] = req.m_r0c1;
   assign m[2] = req.m_r0c2;
   assign m[3] = req.m_r1c0;
   assign m[4] = req.m_r1c1;
   assign m[5] = req.m_r1c2;
   assign m[6] = req.m_r2c0;
   assign m[7] = req.m_r2c1;
   assign m[8] = req.m_r2c2;

   // product stage
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 2*NUM_ELEM; i++) begin
            prod_ff[i] <= PROD_BITS'(m[PROD_A[i]] * m[PROD_B[i]]);
         end
         row0_s1_ff <= {m[2], m[1], m[0]};
      end
   end

   // cofactor stage
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NUM_ELEM; i++) begin
            cof_ff[i] <= COF_BITS'(prod_ff[2*i]) - COF_BITS'(prod_ff[2*i+1]);
         end
         row0_ff <= row0_s1_ff;
      end
   end

   assign cof  = cof_ff;
   assign row0 = row0_ff;

endmodule

### design/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// Determinant by expansion along row 0 in three stages (split partial
// products, terms, sum), then a stage that forms magnitudes, signs and the
// saturated determinant word for the divider lanes.
// ----------------------------------------------------------------------------
module mi3_det #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          adv,
   input  mi3_pkg::mi3_cof_type [mi3_pkg::NUM_ELEM-1:0]  cof,
   input  mi3_pkg::mi3_word_type [2:0]                   row0,
   output mi3_pkg::mi3_mag_type [mi3_pkg::NUM_ELEM-1:0]  cmag,
   output mi3_pkg::mi3_dmag_type                         dmag,
   output mi3_pkg::mi3_side_type                         side
);
   import mi3_pkg::*;

   localparam int TERM_BITS = 3 * WORD_BITS + 1;
   localparam int PART_BITS = 2 * WORD_BITS + 1;
   localparam mi3_dmag_type HALF = DET_BITS'(1) << (WORD_BITS - 1);

   logic signed [PART_BITS-1:0] lo_p_ff [3];
   logic signed [PART_BITS-1:0] hi_p_ff [3];
   logic signed [TERM_BITS-1:0] term_ff [3];
   logic signed [DET_BITS-1:0]  det_ff;
   mi3_cof_type [NUM_ELEM-1:0]  cof_s3_ff, cof_s4_ff, cof_s5_ff;
   mi3_mag_type [NUM_ELEM-1:0]  cmag_ff;
   mi3_dmag_type                dmag_ff;
   mi3_side_type                side_ff;

   mi3_dmag_type                dmag_in;
   mi3_dmag_type                dq;
   logic                        dneg;
   mi3_side_type                side_in;
   mi3_mag_type [NUM_ELEM-1:0]  cmag_in;

   // split partial products: each of the three row-0 cofactors cut into a low and a high half
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            lo_p_ff[k] <= PART_BITS'(row0[k] * $signed({1'b0, cof[3*k][WORD_BITS-1:0]}));
            hi_p_ff[k] <= PART_BITS'(row0[k] * $signed(cof[3*k][COF_BITS-1:WORD_BITS]));
         end
         cof_s3_ff <= cof;
      end
   end

   // recombine each term
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            term_ff[k] <= (TERM_BITS'(hi_p_ff[k]) <<< WORD_BITS) + TERM_BITS'(lo_p_ff[k]);
         end
         cof_s4_ff <= cof_s3_ff;
      end
   end

   // sum of the three terms
   always_ff @(posedge clock) begin
      if (adv) begin
         det_ff    <= DET_BITS'(term_ff[0]) + DET_BITS'(term_ff[1]) + DET_BITS'(term_ff[2]);
         cof_s5_ff <= cof_s4_ff;
      end
   end

   // magnitudes, quotient signs and saturated determinant
   always_comb begin
      dneg    = det_ff[DET_BITS-1];
      dmag_in = dneg ? mi3_dmag_type'(-det_ff) : mi3_dmag_type'(det_ff);
      dq      = dmag_in >> (2 * FRAC_BITS);
      side_in.singular = (det_ff == '0);
      for (int i = 0; i < NUM_ELEM; i++) begin
         cmag_in[i] = cof_s5_ff[i][COF_BITS-1] ?
                      MAG_BITS'(-cof_s5_ff[i]) : MAG_BITS'(cof_s5_ff[i]);
         side_in.neg[i] = cof_s5_ff[i][COF_BITS-1] ^ dneg;
      end
      if (!dneg) begin
         side_in.det_sat  = (dq >= HALF);
         side_in.det_word = side_in.det_sat ? {1'b0, {(WORD_BITS-1){1'b1}}}
                                            : dq[WORD_BITS-1:0];
      end else begin
         side_in.det_sat  = (dq > HALF);
         side_in.det_word = side_in.det_sat ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                            : -dq[WORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cmag_ff <= cmag_in;
         dmag_ff <= dmag_in;
         side_ff <= side_in;
      end
   end

   assign cmag = cmag_ff;
   assign dmag = dmag_ff;
   assign side = side_ff;

endmodule

### design/mi3_div_lane.sv
// ----------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider for one element: an overflow check stage,
// then one quotient bit per stage, most significant first.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                           clock,
   input  logic                                           adv,
   input  mi3_pkg::mi3_mag_type                           cmag,
   input  mi3_pkg::mi3_dmag_type [mi3_pkg::WORD_BITS:0]   dmag_line,
   output logic [mi3_pkg::WORD_BITS-1:0]                  quot,
   output logic                                           ovf
);
   import mi3_pkg::*;

   localparam int NUM_BITS = MAG_BITS + 2 * FRAC_BITS;
   localparam int SHF_BITS = DET_BITS + WORD_BITS;
   localparam int REM_BITS = ((NUM_BITS > SHF_BITS) ? NUM_BITS : SHF_BITS) + 1;

   logic [REM_BITS-1:0]  rem_ff [WORD_BITS];
   logic [WORD_BITS-1:0] q_ff   [WORD_BITS+1];
   logic                 ovf_ff [WORD_BITS+1];
   logic [REM_BITS-1:0]  num;

   assign num = REM_BITS'(cmag) << (2 * FRAC_BITS);

   // quotient of 2^WORD_BITS or more saturates
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= num;
         q_ff[0]   <= '0;
         ovf_ff[0] <= (num >= (REM_BITS'(dmag_line[0]) << WORD_BITS));
      end
   end

   // one quotient bit per stage
   for (genvar k = 1; k <= WORD_BITS; k++) begin : g_bit
      logic [REM_BITS-1:0] shifted;
      logic                fits;

      assign shifted = REM_BITS'(dmag_line[k]) << (WORD_BITS - k);
      assign fits    = (rem_ff[k-1] >= shifted);

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ff[k]   <= {q_ff[k-1][WORD_BITS-2:0], fits};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end

      if (k < WORD_BITS) begin : g_rem
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k] <= fits ? (rem_ff[k-1] - shifted) : rem_ff[k-1];
            end
         end
      end
   end

   assign quot = q_ff[WORD_BITS];
   assign ovf  = ovf_ff[WORD_BITS];

endmodule

### design/mi3_merge.sv
// ----------------------------------------------------------------------------
// mi3_merge
// Combines the nine lane quotients: signs, saturation, singular override and
// flags, then the response register with a skid stage behind it.
// ----------------------------------------------------------------------------
module mi3_merge #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              emit,
   input  logic [mi3_pkg::NUM_ELEM-1:0][mi3_pkg::WORD_BITS-1:0] quot,
   input  logic [mi3_pkg::NUM_ELEM-1:0]                      ovf,
   input  mi3_pkg::mi3_side_type                             side,
   input  logic                                              rsp_stall,
   output logic                                              rsp_valid,
   output mi3_pkg::mi3_rsp_type                              rsp_data,
   output logic                                              skid_full
);
   import mi3_pkg::*;

   localparam logic         ONE_SAT  = (FRAC_BITS >= WORD_BITS - 1);
   localparam mi3_word_type MAX_WORD = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam mi3_word_type MIN_WORD = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam mi3_word_type ONE_WORD = ONE_SAT ? MAX_WORD : (WORD_BITS'(1) << FRAC_BITS);

   mi3_word_type [NUM_ELEM-1:0] inv;
   logic [NUM_ELEM-1:0]         sat;
   mi3_rsp_type                 rsp_in;
   mi3_rsp_type                 out_ff, skid_ff;
   logic                        out_valid_ff, skid_full_ff;
   logic                        take;

   // per-element sign and saturation, singular matrix gives identity
   always_comb begin
      for (int i = 0; i < NUM_ELEM; i++) begin
         if (side.singular) begin
            inv[i] = ((i % 4) == 0) ? ONE_WORD : '0;
            sat[i] = ((i % 4) == 0) ? ONE_SAT : 1'b0;
         end else if (!side.neg[i]) begin
            sat[i] = ovf[i] | quot[i][WORD_BITS-1];
            inv[i] = sat[i] ? MAX_WORD : quot[i];
         end else begin
            sat[i] = ovf[i] | (quot[i][WORD_BITS-1] & (quot[i][WORD_BITS-2:0] != '0));
            inv[i] = sat[i] ? MIN_WORD : -quot[i];
         end
      end
      rsp_in.inv_r0c0       = inv[0];
      rsp_in.inv_r0c1       = inv[1];
      rsp_in.inv_r0c2       = inv[2];
      rsp_in.inv_r1c0       = inv[3];
      rsp_in.inv_r1c1       = inv[4];
      rsp_in.inv_r1c2       = inv[5];
      rsp_in.inv_r2c0       = inv[6];
      rsp_in.inv_r2c1       = inv[7];
      rsp_in.inv_r2c2       = inv[8];
      rsp_in.det_value      = side.singular ? '0 : side.det_word;
      rsp_in.is_singular    = side.singular;
      rsp_in.saturated_flag = (|sat) | (side.det_sat & ~side.singular);
   end

   assign take = out_valid_ff & ~rsp_stall;

   // response register and skid control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         out_valid_ff <= skid_full_ff | emit;
         skid_full_ff <= 1'b0;
      end else if (emit) begin
         skid_full_ff <= 1'b1;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_ff <= skid_full_ff ? skid_ff : rsp_in;
      end else if (emit) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign skid_full = skid_full_ff;

endmodule

### design/matrix3_inverse.sv
// ----------------------------------------------------------------------------
// matrix3_inverse
// Inverse of a signed fixed-point 3x3 matrix by adjugate over determinant,
// nine divider lanes working side by side, merged into one response.
//
//   channel  ports                            carries
//   request  req_valid, req_stall, req_data   one 3x3 matrix
//   response rsp_valid, rsp_stall, rsp_data   inverse, determinant, flags
//
// One matrix is taken every cycle while req_stall is low. The path runs
// through two cofactor stages, four determinant stages, then WORD_BITS + 1
// divider stages, one quotient bit per stage, and the response register.
// Reset clears only the valid bits and the skid-full flag. req_stall rises
// when the skid stage behind a stalled response is full, and the whole
// pipeline holds until the response is taken.
// ----------------------------------------------------------------------------
module matrix3_inverse #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mi3_pkg::mi3_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mi3_pkg::mi3_rsp_type rsp_data
);
   import mi3_pkg::*;

   localparam int LAT = WORD_BITS + 7;

   logic                                   adv;
   logic                                   skid_full;
   logic                                   valid_ff [LAT];
   mi3_cof_type [NUM_ELEM-1:0]             cof;
   mi3_word_type [2:0]                     row0;
   mi3_mag_type [NUM_ELEM-1:0]             cmag;
   mi3_dmag_type                           dmag;
   mi3_side_type                           side;
   mi3_dmag_type                           dmag_ff [WORD_BITS];
   mi3_dmag_type [WORD_BITS:0]             dmag_line;
   mi3_side_type                           side_ff [WORD_BITS+1];
   logic [NUM_ELEM-1:0][WORD_BITS-1:0]     quot;
   logic [NUM_ELEM-1:0]                    ovf;

   assign adv       = ~skid_full;
   assign req_stall = skid_full;

   // request valid line through the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) valid_ff[i] <= 1'b0;
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) valid_ff[i] <= valid_ff[i-1];
      end
   end

   mi3_cofactor u_cofactor (
      .clock (clock),
      .adv   (adv),
      .req   (req_data),
      .cof   (cof),
      .row0  (row0)
   );

   mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
      .clock (clock),
      .adv   (adv),
      .cof   (cof),
      .row0  (row0),
      .cmag  (cmag),
      .dmag  (dmag),
      .side  (side)
   );

   // divisor and side information ride beside the lanes
   always_ff @(posedge clock) begin
      if (adv) begin
         dmag_ff[0] <= dmag;
         side_ff[0] <= side;
         for (int k = 1; k < WORD_BITS; k++) dmag_ff[k] <= dmag_ff[k-1];
         for (int k = 1; k <= WORD_BITS; k++) side_ff[k] <= side_ff[k-1];
      end
   end

   always_comb begin
      dmag_line[0] = dmag;
      for (int k = 1; k <= WORD_BITS; k++) dmag_line[k] = dmag_ff[k-1];
   end

   // nine divider lanes
   for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
      mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock     (clock),
         .adv       (adv),
         .cmag      (cmag[i]),
         .dmag_line (dmag_line),
         .quot      (quot[i]),
         .ovf       (ovf[i])
      );
   end

   mi3_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .emit      (adv & valid_ff[LAT-1]),
      .quot      (quot),
      .ovf       (ovf),
      .side      (side_ff[WORD_BITS]),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .skid_full (skid_full)
   );

endmodule
